### rtl/sjis_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sjis_pkg
// Shared constants and codes for the SJIS glyph offset calculator.
// ----------------------------------------------------------------------------
package sjis_pkg;

  typedef enum logic [1:0] {
    KIND_HALF_ONE = 2'd0,
    KIND_HALF_TWO = 2'd1,
    KIND_FULL     = 2'd2
  } glyph_kind_t;

  localparam logic [1:0] USED_ONE = 2'd1;
  localparam logic [1:0] USED_TWO = 2'd2;

  // half-width font segments
  localparam logic [15:0] HALF_BASE_A = 16'h1346;
  localparam logic [15:0] HALF_BASE_B = 16'h34BF;
  localparam logic [15:0] HALF_BASE_C = 16'h4226;
  localparam logic [15:0] HALF_STEP_A = 16'd126;
  localparam logic [15:0] HALF_STEP_B = 16'd127;
  localparam logic [15:0] HALF_STEP_C = 16'd129;

  // full-width font
  localparam logic [31:0] FULL_SPACE  = 32'h0000_0467;
  localparam logic [31:0] FULL_QMARK  = 32'h0000_0987;
  localparam logic [31:0] SYM_STEP    = 32'd164;
  localparam logic [31:0] CYR_STEP    = 32'd165;
  localparam logic [31:0] ROW_SPAN    = 32'd11055;
  localparam logic [31:0] ROW_STRIDE  = ROW_SPAN + CYR_STEP;
  localparam logic [31:0] KANJI1_BASE = 32'd87162;
  localparam logic [31:0] KANJI2_BASE = 32'd80067;
  localparam logic [31:0] KANJI3_SUB  = 32'd2634348;
  localparam logic [15:0] SYM_FIRST   = 16'h8140;
  localparam logic [15:0] CYR_FIRST   = 16'h8440;
  localparam logic [15:0] KANJI_FIRST = 16'h889F;

  // symbol block adjustments, two's complement
  localparam logic [31:0] SYM_ADJ_0  = 32'd1127;
  localparam logic [31:0] SYM_ADJ_1  = 32'd963;
  localparam logic [31:0] SYM_ADJ_2  = 32'd0 - 32'd841;
  localparam logic [31:0] SYM_ADJ_3  = 32'd0 - 32'd2153;
  localparam logic [31:0] SYM_ADJ_4  = 32'd0 - 32'd3957;
  localparam logic [31:0] SYM_ADJ_5  = 32'd0 - 32'd5105;
  localparam logic [31:0] SYM_ADJ_6  = 32'd0 - 32'd5761;
  localparam logic [31:0] SYM_ADJ_7  = 32'd0 - 32'd19209;
  localparam logic [31:0] SYM_ADJ_8  = 32'd0 - 32'd20357;
  localparam logic [31:0] SYM_ADJ_9  = 32'd0 - 32'd21505;
  localparam logic [31:0] SYM_ADJ_10 = 32'd0 - 32'd22161;
  localparam logic [31:0] SYM_ADJ_11 = 32'd0 - 32'd34953;
  localparam logic [31:0] SYM_ADJ_12 = 32'd0 - 32'd35117;
  localparam logic [31:0] SYM_ADJ_13 = 32'd0 - 32'd36429;
  localparam logic [31:0] SYM_ADJ_14 = 32'd0 - 32'd37741;

  localparam logic [31:0] CYR_ADJ_0 = 32'd70992;
  localparam logic [31:0] CYR_ADJ_1 = 32'd68517;
  localparam logic [31:0] CYR_ADJ_2 = 32'd68352;
  localparam logic [31:0] CYR_ADJ_3 = 32'd66207;

endpackage
`default_nettype wire

### rtl/sjis_half_off.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sjis_half_off
// Half-width byte test and three-segment half-font offset.
// ----------------------------------------------------------------------------
module sjis_half_off (
  input  wire logic [7:0]  byte_in,
  output logic             is_half,
  output logic [15:0]      offset
);

  logic [15:0] base;
  logic [15:0] step;
  logic [7:0]  idx;

  always_comb begin
    is_half = ((byte_in >= 8'h20) && (byte_in <= 8'h7E)) ||
              ((byte_in >= 8'hA1) && (byte_in <= 8'hDF));
    if (byte_in <= 8'h63) begin
      base = sjis_pkg::HALF_BASE_A;
      step = sjis_pkg::HALF_STEP_A;
      idx  = byte_in - 8'h20;
    end else if (byte_in <= 8'h7E) begin
      base = sjis_pkg::HALF_BASE_B;
      step = sjis_pkg::HALF_STEP_B;
      idx  = byte_in - 8'h64;
    end else begin
      base = sjis_pkg::HALF_BASE_C;
      step = sjis_pkg::HALF_STEP_C;
      idx  = byte_in - 8'hA1;
    end
    offset = base + ({8'd0, idx} * step);
  end

endmodule
`default_nettype wire

### rtl/sjis_full_off.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sjis_full_off
// Full-width font offset from a double-byte code via the range table.
// ----------------------------------------------------------------------------
module sjis_full_off (
  input  wire logic [7:0]  hi,
  input  wire logic [7:0]  lo,
  output logic [31:0]      offset
);

  logic [15:0] code;
  logic [31:0] sym_prod;
  logic [31:0] cyr_prod;
  logic [31:0] kan_prod;
  logic [31:0] sym_adj;
  logic [31:0] cyr_adj;
  logic [7:0]  row;
  logic [31:0] row_prod;
  logic [31:0] kan_base;
  logic [31:0] kan_val;
  logic        lo_low;
  logic        in_k1a;
  logic        in_k1;
  logic        in_k2;
  logic        in_k3;

  always_comb begin
    code     = {hi, lo};
    sym_prod = {16'd0, code - sjis_pkg::SYM_FIRST} * sjis_pkg::SYM_STEP;
    cyr_prod = {16'd0, code - sjis_pkg::CYR_FIRST} * sjis_pkg::CYR_STEP;
    kan_prod = {16'd0, code - sjis_pkg::KANJI_FIRST} * sjis_pkg::CYR_STEP;

    if      (code <= 16'h817E) sym_adj = sjis_pkg::SYM_ADJ_0;
    else if (code <= 16'h81AC) sym_adj = sjis_pkg::SYM_ADJ_1;
    else if (code <= 16'h81BF) sym_adj = sjis_pkg::SYM_ADJ_2;
    else if (code <= 16'h81CE) sym_adj = sjis_pkg::SYM_ADJ_3;
    else if (code <= 16'h81E8) sym_adj = sjis_pkg::SYM_ADJ_4;
    else if (code <= 16'h81F7) sym_adj = sjis_pkg::SYM_ADJ_5;
    else if (code == 16'h81FC) sym_adj = sjis_pkg::SYM_ADJ_6;
    else if (code <= 16'h8258) sym_adj = sjis_pkg::SYM_ADJ_7;
    else if (code <= 16'h8279) sym_adj = sjis_pkg::SYM_ADJ_8;
    else if (code <= 16'h829A) sym_adj = sjis_pkg::SYM_ADJ_9;
    else if (code <= 16'h82F1) sym_adj = sjis_pkg::SYM_ADJ_10;
    else if (code <= 16'h837E) sym_adj = sjis_pkg::SYM_ADJ_11;
    else if (code <= 16'h8396) sym_adj = sjis_pkg::SYM_ADJ_12;
    else if (code <= 16'h83B6) sym_adj = sjis_pkg::SYM_ADJ_13;
    else if (code >= 16'h83BF) sym_adj = sjis_pkg::SYM_ADJ_14;
    else                       sym_adj = 32'd0;

    if      (code <= 16'h8460) cyr_adj = sjis_pkg::CYR_ADJ_0;
    else if (code <= 16'h847E) cyr_adj = sjis_pkg::CYR_ADJ_1;
    else if (code <= 16'h8491) cyr_adj = sjis_pkg::CYR_ADJ_2;
    else if (code >= 16'h849F) cyr_adj = sjis_pkg::CYR_ADJ_3;
    else                       cyr_adj = 32'd0;

    in_k1a = (code >= 16'h889F) && (code <= 16'h88FC);
    in_k1  = (code >= 16'h8940) && (code <= 16'h9872);
    in_k2  = (code >= 16'h989F) && (code <= 16'h9FFC);
    in_k3  = (code >= 16'hE040) && (code <= 16'hEAA4);
    lo_low = (lo <= 8'h7E);

    // kanji rows: code product + base - row * (row span + step), with a one-step trim
    if (in_k3) begin
      row      = hi - 8'hC9;
      kan_base = (32'd0 - sjis_pkg::KANJI3_SUB) -
                 (lo_low ? 32'd0 : sjis_pkg::CYR_STEP);
    end else begin
      row      = hi - 8'h88;
      kan_base = (in_k2 ? sjis_pkg::KANJI2_BASE : sjis_pkg::KANJI1_BASE) +
                 (lo_low ? sjis_pkg::CYR_STEP : 32'd0);
    end
    row_prod = {24'd0, row} * sjis_pkg::ROW_STRIDE;
    kan_val  = kan_prod + kan_base - row_prod;

    if ((code >= sjis_pkg::SYM_FIRST) && (code <= 16'h83D6)) begin
      offset = sym_prod + sym_adj;
    end else if ((code >= sjis_pkg::CYR_FIRST) && (code <= 16'h84BE)) begin
      offset = cyr_prod + cyr_adj;
    end else if ((code >= 16'h8740) && (code <= 16'h879E)) begin
      offset = sjis_pkg::FULL_QMARK;
    end else if (in_k1a) begin
      offset = kan_prod + sjis_pkg::KANJI1_BASE;
    end else if (in_k1 || in_k2 || in_k3) begin
      offset = (lo == 8'h7F) ? sjis_pkg::FULL_SPACE : kan_val;
    end else begin
      offset = sjis_pkg::FULL_SPACE;
    end
  end

endmodule
`default_nettype wire

### rtl/sjis_glyph_offset_calc_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sjis_glyph_offset_calc_core
// SJIS lead/trail byte pair to half- and full-font glyph byte offsets.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with in_lead_byte and in_trail_byte.
// Result channel: out_valid / out_stall with out_glyph_kind, out_first_offset,
// out_second_offset and out_bytes_used. A transfer takes place on a rising
// edge with valid high and stall low.
// Path from input transfer to result transfer: the input register, then the
// range compares and constant multiplies, then the result register; out_valid
// rises when the result register loads from a full input register.
// One transfer per cycle is sustained on both sides while out_stall is low.
// When out_stall is held, the result register keeps its value, the input
// register fills behind it and in_stall then rises; nothing is dropped.
// Synchronous reset (rst_n low) empties both registers; no set-up is needed.
// ----------------------------------------------------------------------------
module sjis_glyph_offset_calc_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_lead_byte,
  input  wire logic [7:0]  in_trail_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_glyph_kind,
  output logic [31:0]      out_first_offset,
  output logic [15:0]      out_second_offset,
  output logic [1:0]       out_bytes_used
);

  logic        s1_valid_r;
  logic [7:0]  lead_r;
  logic [7:0]  trail_r;
  logic        out_valid_r;
  logic [1:0]  kind_r;
  logic [31:0] first_r;
  logic [15:0] second_r;
  logic [1:0]  used_r;

  logic        out_load;
  logic        s1_load;
  logic        lead_half;
  logic        trail_half;
  logic [15:0] lead_off;
  logic [15:0] trail_off;
  logic [31:0] full_off;
  logic [1:0]  kind_nxt;
  logic [31:0] first_nxt;
  logic [15:0] second_nxt;
  logic [1:0]  used_nxt;

  sjis_half_off u_half_lead (
    .byte_in (lead_r),
    .is_half (lead_half),
    .offset  (lead_off)
  );

  sjis_half_off u_half_trail (
    .byte_in (trail_r),
    .is_half (trail_half),
    .offset  (trail_off)
  );

  sjis_full_off u_full (
    .hi     (lead_r),
    .lo     (trail_r),
    .offset (full_off)
  );

  assign out_load = !out_valid_r || !out_stall;
  assign s1_load  = !s1_valid_r || out_load;
  assign in_stall = !s1_load;

  always_comb begin
    second_nxt = 16'd0;
    if (lead_half) begin
      first_nxt = {16'd0, lead_off};
      if (trail_half) begin
        kind_nxt   = sjis_pkg::KIND_HALF_TWO;
        second_nxt = trail_off;
        used_nxt   = sjis_pkg::USED_TWO;
      end else begin
        kind_nxt = sjis_pkg::KIND_HALF_ONE;
        used_nxt = sjis_pkg::USED_ONE;
      end
    end else begin
      first_nxt = full_off;
      kind_nxt  = sjis_pkg::KIND_FULL;
      used_nxt  = sjis_pkg::USED_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= in_valid;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      lead_r  <= in_lead_byte;
      trail_r <= in_trail_byte;
    end
    if (out_load && s1_valid_r) begin
      kind_r   <= kind_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      used_r   <= used_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_glyph_kind    = kind_r;
  assign out_first_offset  = first_r;
  assign out_second_offset = second_r;
  assign out_bytes_used    = used_r;

  // a transfer in always lands in the input register
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> s1_valid_r)
    else $error("input transfer lost");

  // input register only stalls behind a stalled, full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without cause");

  a_one_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_glyph_kind == sjis_pkg::KIND_HALF_ONE)) |->
      ((out_bytes_used == sjis_pkg::USED_ONE) && (out_second_offset == 16'd0)))
    else $error("single half-width result malformed");

  a_full_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_glyph_kind == sjis_pkg::KIND_FULL)) |->
      ((out_bytes_used == sjis_pkg::USED_TWO) && (out_second_offset == 16'd0)))
    else $error("full-width result malformed");

endmodule
`default_nettype wire
